// ===== design/nfst_pkg.sv =====
package nfst_pkg;

	localparam int unsigned SLOTS      = 16;
	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned OP_W       = 2;
	localparam int unsigned RANK_W     = 4;
	localparam int unsigned SLOT_W     = $clog2(SLOTS);
	localparam int unsigned CNT_W      = $clog2(SLOTS + 1);

	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [RANK_W-1:0]     rank_t;
	typedef logic [OP_W-1:0]       op_t;

	localparam cnt_t  SLOTS_C   = CNT_W'(SLOTS);
	localparam slot_t LAST_SLOT = SLOT_W'(SLOTS - 1);

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_REMOVE = 2'd1;
	localparam op_t OP_SELECT = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_MISS  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

// ===== design/nfst_ifs.sv =====
interface nfst_req_if;
	logic                 valid;
	logic                 ready;
	nfst_pkg::op_t        op;
	nfst_pkg::value_t     item_value;
	nfst_pkg::rank_t      rank;

	modport source (output valid, op, item_value, rank, input ready);
	modport sink   (input valid, op, item_value, rank, output ready);
endinterface

interface nfst_rsp_if;
	logic                 valid;
	logic                 ready;
	nfst_pkg::status_t    status;
	nfst_pkg::slot_t      slot;
	nfst_pkg::value_t     found_value;
	nfst_pkg::cnt_t       live_count;

	modport source (output valid, status, slot, found_value, live_count, input ready);
	modport sink   (input valid, status, slot, found_value, live_count, output ready);
endinterface

// ===== design/nfst_ram.sv =====
module nfst_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/next_fit_slot_table.sv =====
// Channel  Role  Payload
// req      sink  op, item_value, rank
// rsp      src   status, slot, found_value, live_count
//
// One request is worked on at a time; a finished result waits in the output register
// while the next request is accepted. Insert probes one valid bit per cycle from the
// next-fit slot; remove and select read one slot per cycle through the store RAM
// read port. Reset clears all valid marks, the next-fit pointer and the live count;
// the store itself is not cleared. A stalled result holds its slot until the sink
// takes it.
module next_fit_slot_table (
	input logic         clk,
	input logic         arst_n,
	nfst_req_if.sink    req,
	nfst_rsp_if.source  rsp
);

	typedef enum logic [1:0] {S_IDLE, S_INS, S_SCAN, S_POST} state_t;

	state_t                       state_q;
	nfst_pkg::op_t                op_q;
	nfst_pkg::value_t             val_q;
	nfst_pkg::rank_t              left_q;
	logic [nfst_pkg::SLOTS-1:0]   valid_q;
	nfst_pkg::slot_t              next_fit_q;
	nfst_pkg::slot_t              pos_q;
	nfst_pkg::cnt_t               count_q;
	nfst_pkg::cnt_t               cnt_q;
	logic                         vld_s1;
	nfst_pkg::slot_t              slot_s1;
	nfst_pkg::status_t            pst_q;
	nfst_pkg::slot_t              pslot_q;
	nfst_pkg::value_t             pval_q;
	logic                         out_vld_q;
	nfst_pkg::status_t            ost_q;
	nfst_pkg::slot_t              oslot_q;
	nfst_pkg::value_t             oval_q;
	nfst_pkg::cnt_t               ocnt_q;

	logic                         ram_we;
	nfst_pkg::slot_t              ram_raddr;
	nfst_pkg::value_t             ram_rdata;
	logic                         issue;
	logic                         cur_valid;
	logic                         hit;
	logic                         last;
	logic                         out_free;

	nfst_ram #(
		.WIDTH (nfst_pkg::VALUE_BITS),
		.DEPTH (nfst_pkg::SLOTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q),
		.wdata (val_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = (state_q == S_INS) && !valid_q[pos_q];
		issue     = (state_q == S_SCAN) && (cnt_q < nfst_pkg::SLOTS_C);
		ram_raddr = issue ? cnt_q[nfst_pkg::SLOT_W-1:0] : '0;
		cur_valid = valid_q[slot_s1];
		hit       = vld_s1 && cur_valid &&
		            ((op_q == nfst_pkg::OP_REMOVE) ? (ram_rdata == val_q) : (left_q == '0));
		last      = vld_s1 && (slot_s1 == nfst_pkg::LAST_SLOT);
		out_free  = !out_vld_q || rsp.ready;
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_vld_q;
	assign rsp.status      = ost_q;
	assign rsp.slot        = oslot_q;
	assign rsp.found_value = oval_q;
	assign rsp.live_count  = ocnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= nfst_pkg::OP_INSERT;
			val_q      <= '0;
			left_q     <= '0;
			valid_q    <= '0;
			next_fit_q <= '0;
			pos_q      <= '0;
			count_q    <= '0;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			slot_s1    <= '0;
			pst_q      <= nfst_pkg::ST_OK;
			pslot_q    <= '0;
			pval_q     <= '0;
			out_vld_q  <= 1'b0;
			ost_q      <= nfst_pkg::ST_OK;
			oslot_q    <= '0;
			oval_q     <= '0;
			ocnt_q     <= '0;
		end else begin
			vld_s1  <= issue;
			slot_s1 <= ram_raddr;
			if (state_q == S_POST && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q   <= req.op;
						val_q  <= req.item_value;
						left_q <= req.rank;
						pos_q  <= next_fit_q;
						cnt_q  <= '0;
						pslot_q <= '0;
						pval_q  <= '0;
						case (req.op)
							nfst_pkg::OP_INSERT: begin
								if (count_q == nfst_pkg::SLOTS_C) begin
									pst_q   <= nfst_pkg::ST_FULL;
									state_q <= S_POST;
								end else begin
									state_q <= S_INS;
								end
							end
							nfst_pkg::OP_REMOVE, nfst_pkg::OP_SELECT: begin
								state_q <= S_SCAN;
							end
							default: begin
								pst_q   <= nfst_pkg::ST_OK;
								state_q <= S_POST;
							end
						endcase
					end
				end
				S_INS: begin
					if (!valid_q[pos_q]) begin
						valid_q[pos_q] <= 1'b1;
						count_q        <= count_q + 1'b1;
						next_fit_q     <= (pos_q == nfst_pkg::LAST_SLOT) ? '0 : pos_q + 1'b1;
						pst_q          <= nfst_pkg::ST_OK;
						pslot_q        <= pos_q;
						state_q        <= S_POST;
					end else begin
						pos_q <= (pos_q == nfst_pkg::LAST_SLOT) ? '0 : pos_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (hit) begin
						pst_q   <= nfst_pkg::ST_OK;
						pslot_q <= slot_s1;
						if (op_q == nfst_pkg::OP_REMOVE) begin
							valid_q[slot_s1] <= 1'b0;
							count_q          <= count_q - 1'b1;
							next_fit_q       <= slot_s1;
						end else begin
							pval_q <= ram_rdata;
						end
						state_q <= S_POST;
					end else if (last) begin
						pst_q   <= (op_q == nfst_pkg::OP_REMOVE) ? nfst_pkg::ST_MISS
						                                         : nfst_pkg::ST_RANGE;
						state_q <= S_POST;
					end else if (vld_s1 && cur_valid && op_q == nfst_pkg::OP_SELECT) begin
						left_q <= left_q - 1'b1;
					end
				end
				S_POST: begin
					if (out_free) begin
						ost_q     <= pst_q;
						oslot_q   <= pslot_q;
						oval_q    <= pval_q;
						ocnt_q    <= count_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $countones(valid_q))
		else $error("live count differs from number of valid slots");

	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> valid_q[$past(pos_q)])
		else $error("written slot not marked valid");

	a_remove_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && hit && op_q == nfst_pkg::OP_REMOVE) |=> !valid_q[$past(slot_s1)])
		else $error("removed slot still valid");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST && out_free) |=> out_vld_q && state_q == S_IDLE)
		else $error("result not delivered to output register");
`endif

endmodule
